FILE: src/qfrs_pkg.sv
// ----------------------------------------------------------------------------
// qfrs_pkg
// Shared types and constants for the quoted field row splitter.
// ----------------------------------------------------------------------------
package qfrs_pkg;

	localparam int MaxColumnsDef = 64;
	localparam int OutDepth      = 4;
	localparam int OutPtrW       = $clog2(OutDepth);
	localparam int OutLevelW     = $clog2(OutDepth + 1);

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] SPACE_BYTE   = 8'd32;
	localparam logic [7:0] NUL_BYTE     = 8'd0;

	localparam logic [2:0] REG_DELIM       = 3'd0;
	localparam logic [2:0] REG_EXTRA_DELIM = 3'd1;
	localparam logic [2:0] REG_QUOTE_A     = 3'd2;
	localparam logic [2:0] REG_QUOTE_B     = 3'd3;
	localparam logic [2:0] REG_COMMENT     = 3'd4;
	localparam logic [2:0] REG_EXPECTED    = 3'd5;

	localparam logic [7:0] DELIM_RST       = 8'd32;
	localparam logic [7:0] EXTRA_DELIM_RST = 8'd9;
	localparam logic [7:0] QUOTE_A_RST     = 8'd34;
	localparam logic [7:0] QUOTE_B_RST     = 8'd39;
	localparam logic [7:0] COMMENT_RST     = 8'd35;
	localparam logic [6:0] EXPECTED_RST    = 7'd1;

	localparam logic KIND_CONTENT = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		ST_GOOD      = 2'd0,
		ST_COMMENT   = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] extra_delim;
		logic [7:0] quote_a;
		logic [7:0] quote_b;
		logic [7:0] comment;
		logic [6:0] expected_cols;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  content_byte;
		logic [5:0]  field_index;
		status_t     row_status;
		logic [6:0]  fields_found;
		logic [31:0] row_number;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: src/qfrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// qfrs_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module qfrs_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output qfrs_pkg::cfg_t    cfg
);

	qfrs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim         <= qfrs_pkg::DELIM_RST;
			cfg_q.extra_delim   <= qfrs_pkg::EXTRA_DELIM_RST;
			cfg_q.quote_a       <= qfrs_pkg::QUOTE_A_RST;
			cfg_q.quote_b       <= qfrs_pkg::QUOTE_B_RST;
			cfg_q.comment       <= qfrs_pkg::COMMENT_RST;
			cfg_q.expected_cols <= qfrs_pkg::EXPECTED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				qfrs_pkg::REG_DELIM:       cfg_q.delim         <= cfg_data;
				qfrs_pkg::REG_EXTRA_DELIM: cfg_q.extra_delim   <= cfg_data;
				qfrs_pkg::REG_QUOTE_A:     cfg_q.quote_a       <= cfg_data;
				qfrs_pkg::REG_QUOTE_B:     cfg_q.quote_b       <= cfg_data;
				qfrs_pkg::REG_COMMENT:     cfg_q.comment       <= cfg_data;
				qfrs_pkg::REG_EXPECTED:    cfg_q.expected_cols <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/qfrs_parser.sv
// ----------------------------------------------------------------------------
// qfrs_parser
// Input register, row state and the per-byte split logic; hands up to two
// results per beat to the output buffer.
// ----------------------------------------------------------------------------
module qfrs_parser #(
	parameter int MAX_COLUMNS = qfrs_pkg::MaxColumnsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	input  qfrs_pkg::cfg_t    cfg,
	input  logic              room,
	output qfrs_pkg::push_t   push
);

	localparam logic [6:0] MaxCols = 7'(MAX_COLUMNS);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;
	logic        advance;

	logic [7:0]  open_quote_q;
	logic        inside_q;
	logic [6:0]  fcount_q;
	logic        lead_q;
	logic        comment_q;
	logic        dropped_q;
	logic [31:0] rows_q;

	logic [7:0]  open_quote_n;
	logic        inside_n;
	logic [6:0]  fcount_n;
	logic        lead_n;
	logic        comment_n;
	logic        dropped_n;
	logic [31:0] rows_n;
	qfrs_pkg::push_t push_c;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_comb begin
		logic           is_nl;
		logic           handled;
		logic           emit;
		logic           finish;
		logic           begin_fld;
		qfrs_pkg::result_t rc;
		qfrs_pkg::result_t rv;

		open_quote_n = open_quote_q;
		inside_n     = inside_q;
		fcount_n     = fcount_q;
		lead_n       = lead_q;
		comment_n    = comment_q;
		dropped_n    = dropped_q;
		rows_n       = rows_q;
		is_nl        = (byte_s1 == qfrs_pkg::NEWLINE_BYTE);
		handled      = 1'b0;
		emit         = 1'b0;
		begin_fld    = 1'b0;
		finish       = is_nl || eot_s1;

		if (!is_nl) begin
			if (!comment_q && lead_q && byte_s1 != qfrs_pkg::SPACE_BYTE) begin
				lead_n = 1'b0;
				if (byte_s1 == cfg.comment) begin
					comment_n = 1'b1;
					handled   = 1'b1;
				end
			end
			if (!handled && !comment_q) begin
				if (open_quote_q == qfrs_pkg::NUL_BYTE) begin
					if (byte_s1 == cfg.delim || byte_s1 == cfg.extra_delim) begin
						inside_n = 1'b0;
					end else if (byte_s1 != qfrs_pkg::NUL_BYTE &&
					             (byte_s1 == cfg.quote_a || byte_s1 == cfg.quote_b)) begin
						begin_fld    = 1'b1;
						open_quote_n = byte_s1;
					end else begin
						begin_fld = 1'b1;
						emit      = 1'b1;
					end
				end else if (byte_s1 == open_quote_q) begin
					open_quote_n = qfrs_pkg::NUL_BYTE;
				end else begin
					emit = 1'b1;
				end
				if (begin_fld && !inside_q) begin
					inside_n = 1'b1;
					if (fcount_q < MaxCols) begin
						fcount_n  = fcount_q + 7'd1;
						dropped_n = 1'b0;
					end else begin
						dropped_n = 1'b1;
					end
				end
			end
		end
		emit = emit && !dropped_n && (fcount_n != 7'd0);

		rc              = '0;
		rc.kind         = qfrs_pkg::KIND_CONTENT;
		rc.content_byte = byte_s1;
		rc.field_index  = 6'(fcount_n - 7'd1);
		rc.row_status   = qfrs_pkg::ST_GOOD;
		rc.last_of_run  = !finish;

		rv             = '0;
		rv.kind        = qfrs_pkg::KIND_VERDICT;
		rv.row_number  = rows_q + 32'd1;
		rv.last_of_run = 1'b1;
		rv.fields_found = fcount_n;
		if (comment_n) begin
			rv.row_status   = qfrs_pkg::ST_COMMENT;
			rv.fields_found = 7'd0;
		end else if (fcount_n == cfg.expected_cols) begin
			rv.row_status = qfrs_pkg::ST_GOOD;
		end else if (fcount_n == 7'd0) begin
			rv.row_status = qfrs_pkg::ST_EMPTY;
		end else begin
			rv.row_status = qfrs_pkg::ST_MALFORMED;
		end

		if (finish) begin
			rows_n       = rows_q + 32'd1;
			open_quote_n = qfrs_pkg::NUL_BYTE;
			inside_n     = 1'b0;
			fcount_n     = 7'd0;
			lead_n       = 1'b1;
			comment_n    = 1'b0;
			dropped_n    = 1'b0;
		end

		push_c.r1 = rv;
		if (emit) begin
			push_c.r0    = rc;
			push_c.count = finish ? 2'd2 : 2'd1;
		end else begin
			push_c.r0    = rv;
			push_c.count = finish ? 2'd1 : 2'd0;
		end
		if (!advance) begin
			push_c.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_quote_q <= qfrs_pkg::NUL_BYTE;
			inside_q     <= 1'b0;
			fcount_q     <= 7'd0;
			lead_q       <= 1'b1;
			comment_q    <= 1'b0;
			dropped_q    <= 1'b0;
			rows_q       <= 32'd0;
		end else if (advance) begin
			open_quote_q <= open_quote_n;
			inside_q     <= inside_n;
			fcount_q     <= fcount_n;
			lead_q       <= lead_n;
			comment_q    <= comment_n;
			dropped_q    <= dropped_n;
			rows_q       <= rows_n;
		end
	end

	assign push = push_c;

endmodule

FILE: src/qfrs_out_fifo.sv
// ----------------------------------------------------------------------------
// qfrs_out_fifo
// Result buffer: takes up to two results per cycle, delivers one beat.
// ----------------------------------------------------------------------------
module qfrs_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qfrs_pkg::push_t                     push,
	output logic                                room,
	output logic                                out_valid,
	input  logic                                out_ready,
	output qfrs_pkg::result_t                   head,
	output logic [qfrs_pkg::OutLevelW-1:0]      level
);

	localparam int PtrW = qfrs_pkg::OutPtrW;
	localparam int LvlW = qfrs_pkg::OutLevelW;

	qfrs_pkg::result_t      mem_q [qfrs_pkg::OutDepth];
	logic [PtrW-1:0]        wr_ptr_q;
	logic [PtrW-1:0]        rd_ptr_q;
	logic [LvlW-1:0]        level_q;
	logic                   pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (level_q != '0);
	assign room      = (level_q <= LvlW'(qfrs_pkg::OutDepth - 2));
	assign head      = mem_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PtrW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			level_q <= level_q + LvlW'(push.count) - LvlW'(pop);
		end
	end

endmodule

FILE: src/quoted_field_row_splitter.sv
// Path: an accepted byte is registered in the input register; its results
// are written into the result buffer once it has room, and the first result
// is then offered from the buffer head. A 4-entry result buffer decouples.
// Throughput: one byte per cycle while the result buffer has room; a content
// byte with end_of_text set yields two results and takes two output beats.
// Reset: configuration returns to defaults, row state and row count clear,
// buffer empties.
// ----------------------------------------------------------------------------
// quoted_field_row_splitter
// Splits a text byte stream into quoted/delimited fields and row verdicts.
// ----------------------------------------------------------------------------
module quoted_field_row_splitter #(
	parameter int MAX_COLUMNS = qfrs_pkg::MaxColumnsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  content_byte,
	output logic [5:0]  field_index,
	output logic [1:0]  row_status,
	output logic [6:0]  fields_found,
	output logic [31:0] row_number,
	output logic        last_of_run
);

	qfrs_pkg::cfg_t    cfg;
	qfrs_pkg::push_t   push;
	qfrs_pkg::result_t head;
	logic              room;
	logic [qfrs_pkg::OutLevelW-1:0] level;

	assign cfg_ready = 1'b1;

	qfrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qfrs_parser #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cfg         (cfg),
		.room        (room),
		.push        (push)
	);

	qfrs_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.level     (level)
	);

	assign kind         = head.kind;
	assign content_byte = head.content_byte;
	assign field_index  = head.field_index;
	assign row_status   = head.row_status;
	assign fields_found = head.fields_found;
	assign row_number   = head.row_number;
	assign last_of_run  = head.last_of_run;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= qfrs_pkg::OutLevelW'(qfrs_pkg::OutDepth))
		else $error("result buffer overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> $past(level) <= qfrs_pkg::OutLevelW'(qfrs_pkg::OutDepth - 2)
			|| level <= qfrs_pkg::OutLevelW'(qfrs_pkg::OutDepth - 2))
		else $error("push without room");

	a_content_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == qfrs_pkg::KIND_CONTENT |->
			row_status == 2'(qfrs_pkg::ST_GOOD) && fields_found == 7'd0 &&
			row_number == 32'd0)
		else $error("content beat carries verdict fields");

	a_comment_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == qfrs_pkg::KIND_VERDICT &&
			row_status == 2'(qfrs_pkg::ST_COMMENT) |-> fields_found == 7'd0 && last_of_run)
		else $error("comment verdict with fields");

endmodule
